/* rtl/core/ubds_pkg.sv */
`default_nettype none
package ubds_pkg;

  localparam int unsigned CLK_W   = 27;
  localparam int unsigned BAUD_W  = 24;
  localparam int unsigned RATIO_W = 6;
  localparam int unsigned DIV_W   = 26;
  localparam int unsigned ERR_W   = 25;
  localparam int unsigned DEN_W   = 31;
  localparam int unsigned CALC_W  = CLK_W + 1;

  localparam int unsigned MIN_OVERSAMPLE = 4;
  localparam int unsigned MAX_OVERSAMPLE = 32;

  localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(4000000);

  localparam logic [1:0] DSEL_BR = 2'd0;
  localparam logic [1:0] DSEL_A  = 2'd1;
  localparam logic [1:0] DSEL_B  = 2'd2;

  typedef struct packed {
    logic       load;
    logic       mul_br;
    logic       fix_div;
    logic       mul_ab;
    logic       div_start;
    logic [1:0] div_sel;
    logic       cap_qa;
    logic       cap_qb;
    logic       eval;
    logic       upd;
    logic       next_ratio;
    logic       out_load;
  } ubds_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_ratio;
    logic out_free;
  } ubds_status_t;

endpackage
`default_nettype wire

/* rtl/core/ubds_div.sv */
`default_nettype none
module ubds_div import ubds_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [CLK_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  done,
  output logic [CLK_W-1:0]      quotient
);

  localparam int unsigned CNT_W = $clog2(CLK_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [CLK_W-1:0] rem;
  logic [CLK_W-1:0] quo;
  logic [DEN_W-1:0] dsr;
  logic [CALC_W-1:0] trial;
  logic             ge;
  logic [CALC_W-1:0] diff;

  // one restoring step per cycle
  always_comb begin
    trial = {rem, quo[CLK_W-1]};
    ge    = {{(DEN_W-CALC_W){1'b0}}, trial} >= dsr;
    diff  = trial - dsr[CALC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(CLK_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[CLK_W-1:0] : trial[CLK_W-1:0];
      quo <= {quo[CLK_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule
`default_nettype wire

/* rtl/core/ubds_datapath.sv */
`default_nettype none
module ubds_datapath import ubds_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire ubds_cmd_t                 cmd,
  output ubds_status_t                   status,
  input  wire logic                      cfg_we,
  input  wire logic [CLK_W-1:0]          cfg_clk,
  input  wire logic [BAUD_W-1:0]         target_baud,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  output logic [RATIO_W-1:0]             oversample_ratio,
  output logic [DIV_W-1:0]               baud_divisor,
  output logic signed [ERR_W-1:0]        baud_error
);

  logic [CLK_W-1:0]         src_clk;
  logic [BAUD_W-1:0]        baud;
  logic [RATIO_W-1:0]       ratio;
  logic [DEN_W-1:0]         den_br;
  logic [DEN_W-1:0]         den_a;
  logic [DEN_W-1:0]         den_b;
  logic [DIV_W-1:0]         div;
  logic [CLK_W-1:0]         qa;
  logic [CLK_W-1:0]         qb;
  logic signed [CALC_W-1:0] cand_err;
  logic [DIV_W-1:0]         cand_div;
  logic signed [CALC_W-1:0] best_err;
  logic [DIV_W-1:0]         best_div;
  logic [RATIO_W-1:0]       best_ratio;
  logic [DEN_W-1:0]         divisor_mux;
  logic                     div_done;
  logic [CLK_W-1:0]         quotient;
  logic [DEN_W-1:0]         ratio_x;
  logic [DEN_W-1:0]         div_x;
  logic signed [CALC_W-1:0] err;
  logic signed [CALC_W-1:0] alt;
  logic signed [CALC_W-1:0] baud_s;

  always_comb begin
    ratio_x = {{(DEN_W-RATIO_W){1'b0}}, ratio};
    div_x   = {{(DEN_W-DIV_W){1'b0}}, div};
    baud_s  = $signed({{(CALC_W-BAUD_W){1'b0}}, baud});
    err     = $signed({1'b0, qa}) - baud_s;
    alt     = baud_s - $signed({1'b0, qb});
    case (cmd.div_sel)
      DSEL_A:  divisor_mux = den_a;
      DSEL_B:  divisor_mux = den_b;
      default: divisor_mux = den_br;
    endcase
  end

  ubds_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (src_clk),
    .divisor  (divisor_mux),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      src_clk <= CLK_RESET;
    end else if (cfg_we) begin
      src_clk <= cfg_clk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      baud       <= (target_baud == '0) ? BAUD_W'(1) : target_baud;
      best_err   <= (target_baud == '0) ? CALC_W'(1)
                                        : $signed({{(CALC_W-BAUD_W){1'b0}}, target_baud});
      ratio      <= RATIO_W'(MIN_OVERSAMPLE);
      best_ratio <= RATIO_W'(MIN_OVERSAMPLE);
      best_div   <= DIV_W'(1);
    end
    if (cmd.mul_br) begin
      den_br <= {{(DEN_W-BAUD_W){1'b0}}, baud} * ratio_x;
    end
    if (cmd.fix_div) begin
      div <= (quotient == '0) ? DIV_W'(1) : quotient[DIV_W-1:0];
    end
    if (cmd.mul_ab) begin
      den_a <= ratio_x * div_x;
      den_b <= ratio_x * (div_x + 1'b1);
    end
    if (cmd.cap_qa) begin
      qa <= quotient;
    end
    if (cmd.cap_qb) begin
      qb <= quotient;
    end
    if (cmd.eval) begin
      if (err > alt) begin
        cand_err <= alt;
        cand_div <= div + 1'b1;
      end else begin
        cand_err <= err;
        cand_div <= div;
      end
    end
    if (cmd.upd) begin
      if (cand_err <= best_err) begin
        best_err   <= cand_err;
        best_div   <= cand_div;
        best_ratio <= ratio;
      end
    end
    if (cmd.next_ratio) begin
      ratio <= ratio + 1'b1;
    end
    if (cmd.out_load) begin
      oversample_ratio <= best_ratio;
      baud_divisor     <= best_div;
      baud_error       <= best_err[ERR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    status.div_done   = div_done;
    status.last_ratio = ratio == RATIO_W'(MAX_OVERSAMPLE);
    status.out_free   = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

/* rtl/core/ubds_ctrl.sv */
`default_nettype none
module ubds_ctrl import ubds_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire ubds_status_t status,
  output ubds_cmd_t         cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL1  = 4'd1;
  localparam logic [3:0] S_GO1   = 4'd2;
  localparam logic [3:0] S_WAIT1 = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_GO2   = 4'd5;
  localparam logic [3:0] S_WAIT2 = 4'd6;
  localparam logic [3:0] S_GO3   = 4'd7;
  localparam logic [3:0] S_WAIT3 = 4'd8;
  localparam logic [3:0] S_EVAL  = 4'd9;
  localparam logic [3:0] S_UPD   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul_br = 1'b1;
        state_next = S_GO1;
      end
      S_GO1: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_BR;
        state_next    = S_WAIT1;
      end
      S_WAIT1: begin
        if (status.div_done) begin
          cmd.fix_div = 1'b1;
          state_next  = S_MUL2;
        end
      end
      S_MUL2: begin
        cmd.mul_ab = 1'b1;
        state_next = S_GO2;
      end
      S_GO2: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_A;
        state_next    = S_WAIT2;
      end
      S_WAIT2: begin
        if (status.div_done) begin
          cmd.cap_qa = 1'b1;
          state_next = S_GO3;
        end
      end
      S_GO3: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_B;
        state_next    = S_WAIT3;
      end
      S_WAIT3: begin
        if (status.div_done) begin
          cmd.cap_qb = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (status.last_ratio) begin
          state_next = S_OUT;
        end else begin
          cmd.next_ratio = 1'b1;
          state_next     = S_MUL1;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/uart_baud_divisor_search.sv */
`default_nettype none
// channel  direction  signals                                          transfer when
// cfg      in         cfg_valid, cfg_ready, source_clock_hz            cfg_valid & cfg_ready
// in       in         in_valid, in_ready, target_baud                  in_valid & in_ready
// out      out        out_valid, out_ready, oversample_ratio,          out_valid & out_ready
//                     baud_divisor, baud_error
// 29 ratios, 4 to 32, are tried for each item, from the lowest ratio up
// each ratio needs three 27-step divisions on the one shared divider
// rst is synchronous; it clears control state and restores the 4 MHz clock setting
// a new item is taken once the search is over, while the last result may still wait
// a stalled output holds the finished search until the output register frees
module uart_baud_divisor_search import ubds_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CLK_W-1:0]    source_clock_hz,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [BAUD_W-1:0]   target_baud,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [RATIO_W-1:0]       oversample_ratio,
  output logic [DIV_W-1:0]         baud_divisor,
  output logic signed [ERR_W-1:0]  baud_error
);

  ubds_cmd_t    cmd;
  ubds_status_t status;

  assign cfg_ready = 1'b1;

  ubds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ubds_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_clk          (source_clock_hz),
    .target_baud      (target_baud),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .oversample_ratio (oversample_ratio),
    .baud_divisor     (baud_divisor),
    .baud_error       (baud_error)
  );

endmodule
`default_nettype wire

/* test/baud_search_checker.sv */
module baud_search_checker
  import ubds_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_ready,
  input  wire logic [CLK_W-1:0]    source_clock_hz,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire logic [BAUD_W-1:0]   target_baud,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire logic [RATIO_W-1:0]  oversample_ratio,
  input  wire logic [DIV_W-1:0]    baud_divisor,
  input  wire logic [ERR_W-1:0]    baud_error,
  output int                       mismatches,
  output int                       outstanding
);

  typedef struct packed {
    logic [RATIO_W-1:0]       ratio;
    logic [DIV_W-1:0]         divisor;
    logic signed [ERR_W-1:0]  error;
  } baud_choice_t;

  baud_choice_t      choice_queue[$];
  logic [CLK_W-1:0]  clock_setting;

  initial begin
    mismatches    = 0;
    outstanding   = 0;
    clock_setting = CLK_RESET;
  end

  function automatic baud_choice_t search_baud(input logic [CLK_W-1:0] clock_hz,
                                               input logic [BAUD_W-1:0] rate);
    longint unsigned fclk;
    longint unsigned baud;
    longint unsigned div;
    longint unsigned r;
    longint          err;
    longint          alt;
    longint          best_err;
    baud_choice_t    pick;
    fclk = clock_hz;
    baud = (rate == '0) ? 1 : rate;
    best_err = longint'(baud);
    pick.ratio = RATIO_W'(MIN_OVERSAMPLE);
    pick.divisor = DIV_W'(1);
    for (r = MIN_OVERSAMPLE; r <= MAX_OVERSAMPLE; r++) begin
      div = fclk / (baud * r);
      if (div == 0) begin
        div = 1;
      end
      err = longint'(fclk / (r * div)) - longint'(baud);
      alt = longint'(baud) - longint'(fclk / (r * (div + 1)));
      if (err > alt) begin
        err = alt;
        div = div + 1;
      end
      // later ratio wins a tie
      if (err <= best_err) begin
        best_err = err;
        pick.ratio = RATIO_W'(r);
        pick.divisor = DIV_W'(div);
      end
    end
    pick.error = ERR_W'(best_err);
    return pick;
  endfunction

  task automatic note_mismatch(input string field, input longint want, input longint got);
    if (mismatches < 10) begin
      $display("mismatch on %s at %0t: expected %0d, got %0d", field, $realtime, want, got);
    end
    mismatches = mismatches + 1;
  endtask

  always @(posedge clk) begin : watch
    baud_choice_t want;
    if (rst) begin
      clock_setting = CLK_RESET;
      choice_queue.delete();
      outstanding <= 0;
    end else begin
      if (in_valid && in_ready) begin
        choice_queue.push_back(search_baud(clock_setting, target_baud));
      end
      if (out_valid && out_ready) begin
        if (choice_queue.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result transfer at %0t", $realtime);
          end
          mismatches = mismatches + 1;
        end else begin
          want = choice_queue.pop_front();
          if (oversample_ratio !== want.ratio) begin
            note_mismatch("oversample_ratio", want.ratio, oversample_ratio);
          end
          if (baud_divisor !== want.divisor) begin
            note_mismatch("baud_divisor", want.divisor, baud_divisor);
          end
          if (baud_error !== want.error) begin
            note_mismatch("baud_error", want.error, $signed(baud_error));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        clock_setting = source_clock_hz;
      end
      outstanding <= choice_queue.size();
    end
  end

endmodule

/* test/uart_baud_divisor_search_test.sv */
module uart_baud_divisor_search_test;
  import ubds_pkg::*;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CLK_W-1:0]         source_clock_hz = CLK_RESET;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [BAUD_W-1:0]        target_baud = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [RATIO_W-1:0]       oversample_ratio;
  logic [DIV_W-1:0]         baud_divisor;
  logic signed [ERR_W-1:0]  baud_error;
  int                       mismatches;
  int                       outstanding;
  logic                     burst_mode = 1'b0;
  int unsigned              stall_left = 0;
  logic [CLK_W-1:0]         clock_now = CLK_RESET;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  uart_baud_divisor_search dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .source_clock_hz  (source_clock_hz),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .target_baud      (target_baud),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .oversample_ratio (oversample_ratio),
    .baud_divisor     (baud_divisor),
    .baud_error       (baud_error)
  );

  baud_search_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .source_clock_hz  (source_clock_hz),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .target_baud      (target_baud),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .oversample_ratio (oversample_ratio),
    .baud_divisor     (baud_divisor),
    .baud_error       (baud_error),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

  // occasional long stall after a transfer so a finished search has to wait
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready && !burst_mode && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 6000);
      out_ready <= 1'b0;
    end else begin
      out_ready <= burst_mode || ($urandom_range(0, 99) >= 35);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned gap;
    gap = 0;
    if (burst_mode) begin
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(1, 3000);
    end
    while ($urandom_range(0, 99) < 35) begin
      gap++;
    end
    return gap;
  endfunction

  function automatic logic [CLK_W-1:0] pick_clock();
    logic [CLK_W-1:0] common_clocks[9];
    common_clocks = '{1843200, 3686400, 4000000, 8000000, 12000000, 16000000,
                      24000000, 48000000, 96000000};
    case ($urandom_range(0, 3))
      0: return CLK_W'($urandom_range(1, 134217727));
      1: return common_clocks[$urandom_range(0, 8)];
      2: return CLK_W'($urandom_range(1, 100000));
      default: return CLK_W'($urandom_range(1000000, 134217727));
    endcase
  endfunction

  function automatic logic [BAUD_W-1:0] pick_rate();
    int unsigned std_rates[12];
    longint      near;
    std_rates = '{300, 1200, 2400, 4800, 9600, 19200, 38400, 57600, 115200,
                  230400, 460800, 921600};
    if ($urandom_range(0, 49) == 0) begin
      return '0;
    end
    case ($urandom_range(0, 3))
      0: return BAUD_W'($urandom_range(1, 16777215));
      1: return BAUD_W'($urandom_range(1, 1000000));
      2: begin
        // close to an exact ratio and divisor pair
        near = longint'(clock_now) / ($urandom_range(4, 32) * $urandom_range(1, 64));
        near = near + longint'($urandom_range(0, 4)) - 2;
        if (near < 1 || near > 16777215) begin
          near = $urandom_range(1, 100);
        end
        return BAUD_W'(near);
      end
      default: return BAUD_W'(std_rates[$urandom_range(0, 11)]);
    endcase
  endfunction

  task automatic send_rate(input logic [BAUD_W-1:0] rate);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    target_baud <= rate;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic set_source_clock(input logic [CLK_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    source_clock_hz <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    clock_now = value;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset clock setting
    send_rate(BAUD_W'(9600));
    send_rate(BAUD_W'(115200));
    send_rate(BAUD_W'(1));
    send_rate(BAUD_W'(0));
    send_rate(BAUD_W'(16777215));
    send_rate(BAUD_W'(3000000));

    set_source_clock(CLK_W'(134217727));
    send_rate(BAUD_W'(1));
    send_rate(BAUD_W'(16777215));
    send_rate(BAUD_W'(9600));
    send_rate(BAUD_W'(24'hAAAAAA));
    send_rate(BAUD_W'(24'h555555));

    // clock too slow for any rate
    set_source_clock(CLK_W'(1));
    send_rate(BAUD_W'(1));
    send_rate(BAUD_W'(9600));

    set_source_clock(CLK_W'(0));
    send_rate(BAUD_W'(12345));
    send_rate(BAUD_W'(16777215));

    set_source_clock(CLK_W'(48000000));
    send_rate(BAUD_W'(115200));
    send_rate(BAUD_W'(921600));

    for (int phase = 0; phase < 5; phase++) begin
      set_source_clock(pick_clock());
      burst_mode <= (phase == 2);
      repeat (40) send_rate(pick_rate());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/ubds_pkg.sv
rtl/core/ubds_div.sv
rtl/core/ubds_datapath.sv
rtl/core/ubds_ctrl.sv
rtl/core/uart_baud_divisor_search.sv
test/baud_search_checker.sv
test/uart_baud_divisor_search_test.sv
